@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the tracker's checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define FRT_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tracker assertion failed");

// Next-cycle implication, disabled while reset is held.
`define FRT_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tracker assertion failed");

`endif

@@ rtl/frt_pkg.sv @@
// ----------------------------------------------------------------------------
// Fragment reassembly tracker package
// Field widths, packet codes, register indices and result action codes.
// ----------------------------------------------------------------------------
package frt_pkg;

  localparam int unsigned FRT_MAX_FRAGS = 64;

  localparam int unsigned FUNC_W    = 1;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned MSG_W     = 16;
  localparam int unsigned FRAG_W    = 8;
  localparam int unsigned CNT_W     = 7;
  localparam int unsigned BYTES_W   = 16;
  localparam int unsigned OFFSET_W  = 24;
  localparam int unsigned ACTION_W  = 3;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [FUNC_W-1:0] FUNC_START  = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_PACKET = 1'b1;

  localparam logic [KIND_W-1:0] KIND_DATA = 2'd0;
  localparam logic [KIND_W-1:0] KIND_NACK = 2'd1;

  localparam logic [CFG_IDX_W-1:0] CFG_MSG_HDR   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PKT_HDR   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_FRAG = 2'd3;

  typedef enum logic [ACTION_W-1:0] {
    ACT_CLEARED         = 3'd0,
    ACT_ACCEPTED        = 3'd1,
    ACT_IGNORED         = 3'd2,
    ACT_DROPPED         = 3'd3,
    ACT_RESEND          = 3'd4,
    ACT_NACK_UNANSWERED = 3'd5,
    ACT_OTHER           = 3'd6
  } action_e;

endpackage

@@ rtl/fragment_reassembly_tracker_core.sv @@
// ----------------------------------------------------------------------------
// Fragment reassembly tracker core
// Receive-side tracking of fragmented page transfers with resend replies.
// ----------------------------------------------------------------------------
// Each input transfer is evaluated against the current message and bitmap,
// and one result transfer follows it. The input stays busy until the result
// is handed on. Start items, ignored, dropped, unanswered or other packets
// and first fragments go from evaluation straight to the result. A resend
// of fragment zero adds the resend size sum when no later fragment follows
// it. A later data fragment, or a resend of a fragment with later fragments
// after it, runs the multiply and offset steps. A resend of a fragment with
// none after it runs those and then the size sum, with the remainder steps
// between them for the last fragment when the maximum data length is
// nonzero. The result then waits until the previous result has been taken.
// A single shared 24-bit adder forms the page offset one multiplier bit per
// cycle and the last-fragment length one remainder bit per cycle.
module fragment_reassembly_tracker_core #(
  parameter int unsigned MAX_FRAGS = frt_pkg::FRT_MAX_FRAGS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [frt_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [frt_pkg::BYTES_W-1:0]     cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [frt_pkg::FUNC_W-1:0]      func_i,
  input  logic [frt_pkg::KIND_W-1:0]      packet_kind_i,
  input  logic [frt_pkg::MSG_W-1:0]       message_number_i,
  input  logic [frt_pkg::FRAG_W-1:0]      fragment_number_i,
  input  logic [frt_pkg::CNT_W-1:0]       total_fragments_i,
  input  logic [frt_pkg::BYTES_W-1:0]     fragment_bytes_i,
  input  logic [frt_pkg::BYTES_W-1:0]     header_bytes_i,
  input  logic [frt_pkg::BYTES_W-1:0]     max_data_bytes_i,
  input  logic                            request_pending_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [frt_pkg::ACTION_W-1:0]    action_o,
  output logic [frt_pkg::OFFSET_W-1:0]    page_offset_o,
  output logic [frt_pkg::BYTES_W-1:0]     copy_bytes_o,
  output logic [frt_pkg::BYTES_W-1:0]     resend_fragment_bytes_o,
  output logic                            message_complete_o
);

  localparam int unsigned IdxW     = (MAX_FRAGS > 1) ? $clog2(MAX_FRAGS) : 1;
  localparam int unsigned BW       = frt_pkg::BYTES_W;
  localparam int unsigned AluW     = frt_pkg::OFFSET_W;
  localparam int unsigned DivW     = BW + 1;
  localparam int unsigned MulSteps = frt_pkg::FRAG_W;
  localparam int unsigned StepW    = $clog2(DivW + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EVAL = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_OFFS = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_RSUM = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  function automatic logic [BW-1:0] sub_sat(input logic [BW-1:0] a, input logic [BW-1:0] b);
    return (a > b) ? a - b : '0;
  endfunction

  logic [2:0] state_q, state_d;

  logic [BW-1:0] mh_q, ph_q, page_q, full_q;

  logic [frt_pkg::FUNC_W-1:0]  func_q;
  logic [frt_pkg::KIND_W-1:0]  kind_q;
  logic [frt_pkg::MSG_W-1:0]   msg_q;
  logic [frt_pkg::FRAG_W-1:0]  frag_q;
  logic [frt_pkg::CNT_W-1:0]   total_q;
  logic [BW-1:0]               fbytes_q, hbytes_q, maxd_q;
  logic                        pend_q;

  logic [frt_pkg::MSG_W-1:0]   cur_msg_q, cur_msg_d;
  logic                        active_q, active_d;
  logic [MAX_FRAGS-1:0]        map_q, map_d;
  logic [frt_pkg::CNT_W-1:0]   count_q, count_d;
  logic [BW-1:0]               first_q, first_d;

  logic [AluW-1:0]             acc_q, mcand_q;
  logic [frt_pkg::FRAG_W-1:0]  mplier_q;
  logic [BW-1:0]               rem_q;
  logic [DivW-1:0]             dvd_q;
  logic [StepW-1:0]            step_q, step_d;
  logic                        need_div_q, need_div_d;
  logic                        need_rsum_q, need_rsum_d;
  logic                        is_nack_q, is_nack_d;

  frt_pkg::action_e            res_action_q;
  logic [AluW-1:0]             res_offset_q;
  logic [BW-1:0]               res_copy_q, res_resend_q;
  logic                        res_complete_q;

  logic                        out_valid_q, out_valid_d;
  frt_pkg::action_e            out_action_q;
  logic [AluW-1:0]             out_offset_q;
  logic [BW-1:0]               out_copy_q, out_resend_q;
  logic                        out_complete_q;

  logic                        in_accept, out_free;

  logic [frt_pkg::MSG_W-1:0]   next_msg;
  logic                        opens, frag_zero, new_open, frag_in, seen, msg_match, msg_only;
  logic [IdxW-1:0]             frag_idx;
  logic [BW-1:0]               data_len, zero_len;
  logic [frt_pkg::CNT_W-1:0]   count_inc;
  logic [MAX_FRAGS-1:0]        base_map;
  logic [frt_pkg::FRAG_W:0]    frag_p1, total_ext;
  logic                        last_frag, more_frags;
  logic [DivW-1:0]             mod_sum;

  frt_pkg::action_e            eval_action;
  logic [BW-1:0]               eval_copy, eval_resend, eval_first;
  logic                        eval_complete, eval_mul, eval_div, eval_rsum;
  logic                        eval_accept, eval_set_first;
  logic [frt_pkg::FRAG_W-1:0]  eval_mplier;

  logic [AluW-1:0]             alu_a, alu_b;
  logic                        alu_sub;
  logic [AluW:0]               alu_r;
  logic                        alu_neg;
  logic [DivW-1:0]             div_sh;
  logic [BW-1:0]               div_rem_next;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // Classification of the held packet against the tracking state.
  assign next_msg   = cur_msg_q + frt_pkg::MSG_W'(1);
  assign opens      = !active_q || (next_msg == msg_q);
  assign frag_zero  = (frag_q == '0);
  assign new_open   = opens && frag_zero && pend_q;
  assign frag_in    = (frag_q < frt_pkg::FRAG_W'(MAX_FRAGS));
  assign frag_idx   = frag_q[IdxW-1:0];
  assign seen       = !new_open && map_q[frag_idx];
  assign msg_match  = new_open || (active_q && (cur_msg_q == msg_q));
  assign msg_only   = frag_zero && ({1'b0, fbytes_q} == ({1'b0, ph_q} + {1'b0, mh_q}));
  assign data_len   = sub_sat(fbytes_q, hbytes_q);
  assign zero_len   = sub_sat(data_len, mh_q);
  assign count_inc  = (new_open ? '0 : count_q) + frt_pkg::CNT_W'(1);
  assign base_map   = new_open ? '0 : map_q;
  assign frag_p1    = {1'b0, frag_q} + (frt_pkg::FRAG_W + 1)'(1);
  assign total_ext  = (frt_pkg::FRAG_W + 1)'(total_q);
  assign last_frag  = (frag_p1 == total_ext);
  assign more_frags = (frag_p1 < total_ext);
  assign mod_sum    = {1'b0, mh_q} + {1'b0, page_q};

  always_comb begin
    eval_action    = frt_pkg::ACT_IGNORED;
    eval_copy      = '0;
    eval_resend    = '0;
    eval_first     = '0;
    eval_complete  = 1'b0;
    eval_mul       = 1'b0;
    eval_div       = 1'b0;
    eval_rsum      = 1'b0;
    eval_accept    = 1'b0;
    eval_set_first = 1'b0;
    eval_mplier    = frag_q;
    if (func_q == frt_pkg::FUNC_START) begin
      eval_action = frt_pkg::ACT_CLEARED;
    end else if (kind_q == frt_pkg::KIND_NACK) begin
      if (pend_q) begin
        eval_action = frt_pkg::ACT_RESEND;
        eval_mul    = !frag_zero;
        if (frag_zero) begin
          eval_copy = sub_sat(maxd_q, mh_q);
        end else if (last_frag) begin
          if (maxd_q == '0) begin
            eval_copy = mod_sum[DivW-1] ? '1 : mod_sum[BW-1:0];
          end else begin
            eval_div = 1'b1;
          end
        end else begin
          eval_copy = maxd_q;
        end
        if (more_frags) begin
          eval_resend = full_q;
        end else begin
          eval_rsum = 1'b1;
        end
      end else begin
        eval_action = frt_pkg::ACT_NACK_UNANSWERED;
      end
    end else if (kind_q != frt_pkg::KIND_DATA) begin
      eval_action = frt_pkg::ACT_OTHER;
    end else if (opens && !new_open) begin
      eval_action = frt_pkg::ACT_IGNORED;
    end else if (!msg_match) begin
      eval_action = frt_pkg::ACT_IGNORED;
    end else if (!frag_in) begin
      eval_action = frt_pkg::ACT_DROPPED;
    end else if (seen) begin
      eval_action = frt_pkg::ACT_IGNORED;
    end else if (!msg_only && frag_zero && !pend_q) begin
      eval_action = frt_pkg::ACT_DROPPED;
    end else begin
      eval_action   = frt_pkg::ACT_ACCEPTED;
      eval_accept   = 1'b1;
      eval_complete = (count_inc == total_q);
      if (msg_only) begin
        eval_set_first = 1'b1;
      end else if (frag_zero) begin
        eval_set_first = 1'b1;
        eval_first     = zero_len;
        eval_copy      = zero_len;
      end else begin
        eval_copy   = data_len;
        eval_mul    = 1'b1;
        eval_mplier = frag_q - frt_pkg::FRAG_W'(1);
      end
    end
  end

  // Shared adder: multiply accumulation, offset adjustment, remainder trial
  // subtraction and the resend size sum.
  assign div_sh = {rem_q, dvd_q[DivW-1]};

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state_q)
      S_MUL: begin
        alu_a = acc_q;
        alu_b = mcand_q;
      end
      S_OFFS: begin
        alu_a   = acc_q;
        alu_b   = is_nack_q ? AluW'(mh_q) : AluW'(first_q);
        alu_sub = is_nack_q;
      end
      S_DIV: begin
        alu_a   = AluW'(div_sh);
        alu_b   = AluW'(maxd_q);
        alu_sub = 1'b1;
      end
      S_RSUM: begin
        alu_a = AluW'(ph_q);
        alu_b = AluW'(res_copy_q);
      end
      default: begin
        alu_sub = 1'b0;
      end
    endcase
  end

  assign alu_r        = {1'b0, alu_a} + (alu_sub ? ~{1'b0, alu_b} : {1'b0, alu_b})
                      + (AluW + 1)'(alu_sub);
  assign alu_neg      = alu_r[AluW];
  assign div_rem_next = alu_neg ? div_sh[BW-1:0] : alu_r[BW-1:0];

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    need_div_d  = need_div_q;
    need_rsum_d = need_rsum_q;
    is_nack_d   = is_nack_q;
    cur_msg_d   = cur_msg_q;
    active_d    = active_q;
    map_d       = map_q;
    count_d     = count_q;
    first_d     = first_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        step_d      = '0;
        need_div_d  = eval_div;
        need_rsum_d = eval_rsum;
        is_nack_d   = (kind_q == frt_pkg::KIND_NACK);
        if (func_q == frt_pkg::FUNC_START) begin
          cur_msg_d = '0;
          active_d  = 1'b0;
          map_d     = '0;
          count_d   = '0;
          first_d   = '0;
        end else if (eval_accept) begin
          cur_msg_d       = msg_q;
          active_d        = 1'b1;
          map_d           = base_map;
          map_d[frag_idx] = 1'b1;
          count_d         = count_inc;
          if (eval_set_first) begin
            first_d = eval_first;
          end
        end
        if (eval_mul) begin
          state_d = S_MUL;
        end else if (eval_rsum) begin
          state_d = S_RSUM;
        end else begin
          state_d = S_DONE;
        end
      end
      S_MUL: begin
        step_d = step_q + StepW'(1);
        if (step_q == StepW'(MulSteps - 1)) begin
          state_d = S_OFFS;
        end
      end
      S_OFFS: begin
        step_d = '0;
        if (need_div_q) begin
          state_d = S_DIV;
        end else if (need_rsum_q) begin
          state_d = S_RSUM;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DIV: begin
        step_d = step_q + StepW'(1);
        if (step_q == StepW'(DivW - 1)) begin
          state_d = need_rsum_q ? S_RSUM : S_DONE;
        end
      end
      S_RSUM: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mh_q        <= BW'(32);
      ph_q        <= BW'(28);
      page_q      <= BW'(4096);
      full_q      <= BW'(1500);
      step_q      <= '0;
      need_div_q  <= 1'b0;
      need_rsum_q <= 1'b0;
      is_nack_q   <= 1'b0;
      cur_msg_q   <= '0;
      active_q    <= 1'b0;
      map_q       <= '0;
      count_q     <= '0;
      first_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      need_div_q  <= need_div_d;
      need_rsum_q <= need_rsum_d;
      is_nack_q   <= is_nack_d;
      cur_msg_q   <= cur_msg_d;
      active_q    <= active_d;
      map_q       <= map_d;
      count_q     <= count_d;
      first_q     <= first_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          frt_pkg::CFG_MSG_HDR:   mh_q   <= cfg_data_i;
          frt_pkg::CFG_PKT_HDR:   ph_q   <= cfg_data_i;
          frt_pkg::CFG_PAGE:      page_q <= cfg_data_i;
          frt_pkg::CFG_FULL_FRAG: full_q <= cfg_data_i;
          default: begin
            mh_q <= mh_q;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      func_q   <= func_i;
      kind_q   <= packet_kind_i;
      msg_q    <= message_number_i;
      frag_q   <= fragment_number_i;
      total_q  <= total_fragments_i;
      fbytes_q <= fragment_bytes_i;
      hbytes_q <= header_bytes_i;
      maxd_q   <= max_data_bytes_i;
      pend_q   <= request_pending_i;
    end
    case (state_q)
      S_EVAL: begin
        res_action_q   <= eval_action;
        res_offset_q   <= '0;
        res_copy_q     <= eval_copy;
        res_resend_q   <= eval_resend;
        res_complete_q <= eval_complete;
        acc_q          <= '0;
        mcand_q        <= AluW'(maxd_q);
        mplier_q       <= eval_mplier;
        rem_q          <= '0;
        dvd_q          <= mod_sum;
      end
      S_MUL: begin
        if (mplier_q[0]) begin
          acc_q <= alu_r[AluW-1:0];
        end
        mcand_q  <= {mcand_q[AluW-2:0], 1'b0};
        mplier_q <= {1'b0, mplier_q[frt_pkg::FRAG_W-1:1]};
      end
      S_OFFS: begin
        res_offset_q <= (is_nack_q && alu_neg) ? '0 : alu_r[AluW-1:0];
      end
      S_DIV: begin
        rem_q <= div_rem_next;
        dvd_q <= {dvd_q[DivW-2:0], 1'b0};
        if (step_q == StepW'(DivW - 1)) begin
          res_copy_q <= div_rem_next;
        end
      end
      S_RSUM: begin
        res_resend_q <= (alu_r[AluW:BW] != '0) ? '1 : alu_r[BW-1:0];
      end
      S_DONE: begin
        if (out_free) begin
          out_action_q   <= res_action_q;
          out_offset_q   <= res_offset_q;
          out_copy_q     <= res_copy_q;
          out_resend_q   <= res_resend_q;
          out_complete_q <= res_complete_q;
        end
      end
      default: begin
        rem_q <= rem_q;
      end
    endcase
  end

  assign out_valid_o             = out_valid_q;
  assign action_o                = out_action_q;
  assign page_offset_o           = out_offset_q;
  assign copy_bytes_o            = out_copy_q;
  assign resend_fragment_bytes_o = out_resend_q;
  assign message_complete_o      = out_complete_q;

endmodule

@@ rtl/frt_checker.sv @@
// ----------------------------------------------------------------------------
// Fragment reassembly tracker checker
// Port-level assertions on the tracker core, attached by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module frt_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [frt_pkg::ACTION_W-1:0]  action_o,
  input logic [frt_pkg::OFFSET_W-1:0]  page_offset_o,
  input logic [frt_pkg::BYTES_W-1:0]   copy_bytes_o,
  input logic [frt_pkg::BYTES_W-1:0]   resend_fragment_bytes_o,
  input logic                          message_complete_o
);

  // Each item is worked on alone, so the input is busy after a transfer.
  `FRT_ASSERT_NEXT(a_busy_after_transfer, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)

  `FRT_ASSERT_IMPL(a_complete_only_accepted, clk_i, rst_ni, out_valid_o && message_complete_o, action_o == frt_pkg::ACT_ACCEPTED)

  `FRT_ASSERT_IMPL(a_resend_size_only_resend, clk_i, rst_ni, out_valid_o && (action_o != frt_pkg::ACT_RESEND), resend_fragment_bytes_o == '0)

  `FRT_ASSERT_NEXT(a_result_held, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(action_o) && $stable(page_offset_o) && $stable(copy_bytes_o))

endmodule

bind fragment_reassembly_tracker_core frt_checker u_frt_checker (.*);

@@ tb/tb_fragment_reassembly_tracker_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fragment reassembly tracker core testbench
// Drives packet headers and start items through the input handshake, predicts
// each result transfer with a behavioural tracker of its own and compares every
// field in order. Directed cases come first, then randomised message sequences
// and noise under several register settings, random idling on both sides and a
// long receiver hold-off that backs the block up.
// ----------------------------------------------------------------------------
module tb_fragment_reassembly_tracker_core;
  import frt_pkg::*;

  localparam logic [KIND_W-1:0] KIND_OTHER    = 2'd2;
  localparam logic [KIND_W-1:0] KIND_RESERVED = 2'd3;
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned DRAIN_CYCLES  = 64;
  localparam int unsigned HOLD_OFF_LONG = 400;
  localparam int unsigned PRINT_CAP     = 50;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [KIND_W-1:0]  kind;
    logic [MSG_W-1:0]   msg;
    logic [FRAG_W-1:0]  frag;
    logic [CNT_W-1:0]   total;
    logic [BYTES_W-1:0] fbytes;
    logic [BYTES_W-1:0] hbytes;
    logic [BYTES_W-1:0] maxd;
    logic               pending;
  } header_t;

  typedef struct {
    action_e             action;
    logic [OFFSET_W-1:0] offset;
    logic [BYTES_W-1:0]  copy;
    logic [BYTES_W-1:0]  resend;
    logic                complete;
  } verdict_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [BYTES_W-1:0]    cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic [FUNC_W-1:0]     func_i = '0;
  logic [KIND_W-1:0]     packet_kind_i = '0;
  logic [MSG_W-1:0]      message_number_i = '0;
  logic [FRAG_W-1:0]     fragment_number_i = '0;
  logic [CNT_W-1:0]      total_fragments_i = '0;
  logic [BYTES_W-1:0]    fragment_bytes_i = '0;
  logic [BYTES_W-1:0]    header_bytes_i = '0;
  logic [BYTES_W-1:0]    max_data_bytes_i = '0;
  logic                  request_pending_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [ACTION_W-1:0]   action_o;
  logic [OFFSET_W-1:0]   page_offset_o;
  logic [BYTES_W-1:0]    copy_bytes_o;
  logic [BYTES_W-1:0]    resend_fragment_bytes_o;
  logic                  message_complete_o;

  logic [15:0] reg_msg_hdr = 16'd32;
  logic [15:0] reg_pkt_hdr = 16'd28;
  logic [15:0] reg_page = 16'd4096;
  logic [15:0] reg_full_frag = 16'd1500;
  logic [15:0] open_msg = '0;
  logic        msg_is_open = 1'b0;
  logic [63:0] frag_seen = '0;
  logic [6:0]  frag_count = '0;
  logic [15:0] first_frag_data = '0;

  verdict_t    verdicts_due[$];
  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_off_req = 0;
  int unsigned stall_left = 0;
  bit          idling_on = 1'b1;

  fragment_reassembly_tracker_core i_dut (
    .clk_i                   (clk_i),
    .rst_ni                  (rst_ni),
    .cfg_we_i                (cfg_we_i),
    .cfg_index_i             (cfg_index_i),
    .cfg_data_i              (cfg_data_i),
    .in_valid_i              (in_valid_i),
    .in_ready_o              (in_ready_o),
    .func_i                  (func_i),
    .packet_kind_i           (packet_kind_i),
    .message_number_i        (message_number_i),
    .fragment_number_i       (fragment_number_i),
    .total_fragments_i       (total_fragments_i),
    .fragment_bytes_i        (fragment_bytes_i),
    .header_bytes_i          (header_bytes_i),
    .max_data_bytes_i        (max_data_bytes_i),
    .request_pending_i       (request_pending_i),
    .out_valid_o             (out_valid_o),
    .out_ready_i             (out_ready_i),
    .action_o                (action_o),
    .page_offset_o           (page_offset_o),
    .copy_bytes_o            (copy_bytes_o),
    .resend_fragment_bytes_o (resend_fragment_bytes_o),
    .message_complete_o      (message_complete_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL fragment_reassembly_tracker_core");
      $finish;
    end
  end

  function automatic logic [31:0] sub_floor(input logic [31:0] a, input logic [31:0] b);
    return (a > b) ? a - b : 32'd0;
  endfunction

  function automatic logic [15:0] clip16(input logic [31:0] v);
    return (v > 32'hFFFF) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic verdict_t track_fragment(input header_t h);
    verdict_t    v;
    logic [31:0] frag, total, maxd, len, sum;
    logic        opens, go, accept;
    frag = 32'(h.frag);
    total = 32'(h.total);
    maxd = 32'(h.maxd);
    v.action = ACT_IGNORED;
    v.offset = '0;
    v.copy = '0;
    v.resend = '0;
    v.complete = 1'b0;
    if (h.func == FUNC_START) begin
      open_msg = '0;
      msg_is_open = 1'b0;
      frag_seen = '0;
      frag_count = '0;
      first_frag_data = '0;
      v.action = ACT_CLEARED;
    end else if (h.kind == KIND_NACK) begin
      if (h.pending) begin
        len = maxd;
        if (frag == 0) begin
          len = sub_floor(maxd, 32'(reg_msg_hdr));
        end else if (frag + 1 == total) begin
          sum = 32'(reg_msg_hdr) + 32'(reg_page);
          len = 32'(clip16((maxd != 0) ? sum % maxd : sum));
        end
        if (frag != 0) v.offset = 24'(sub_floor(frag * maxd, 32'(reg_msg_hdr)));
        v.resend = (frag + 1 < total) ? reg_full_frag : clip16(32'(reg_pkt_hdr) + len);
        v.copy = len[15:0];
        v.action = ACT_RESEND;
      end else begin
        v.action = ACT_NACK_UNANSWERED;
      end
    end else if (h.kind != KIND_DATA) begin
      v.action = ACT_OTHER;
    end else begin
      opens = !msg_is_open || (16'(open_msg + 16'd1) == h.msg);
      go = 1'b1;
      if (opens) begin
        if (frag == 0 && h.pending) begin
          open_msg = h.msg;
          msg_is_open = 1'b1;
          frag_seen = '0;
          frag_count = '0;
        end else begin
          go = 1'b0;
        end
      end
      if (go) begin
        if (!msg_is_open || open_msg != h.msg) begin
          v.action = ACT_IGNORED;
        end else if (frag >= FRT_MAX_FRAGS) begin
          v.action = ACT_DROPPED;
        end else if (frag_seen[frag[5:0]]) begin
          v.action = ACT_IGNORED;
        end else begin
          accept = 1'b1;
          if (frag == 0 && 32'(h.fbytes) == 32'(reg_pkt_hdr) + 32'(reg_msg_hdr)) begin
            first_frag_data = '0;
          end else begin
            len = sub_floor(32'(h.fbytes), 32'(h.hbytes));
            if (frag == 0) begin
              if (!h.pending) begin
                accept = 1'b0;
                v.action = ACT_DROPPED;
              end else begin
                len = sub_floor(len, 32'(reg_msg_hdr));
                first_frag_data = len[15:0];
              end
            end else begin
              v.offset = 24'(32'(first_frag_data) + (frag - 1) * maxd);
            end
            v.copy = len[15:0];
          end
          if (accept) begin
            frag_seen[frag[5:0]] = 1'b1;
            frag_count = frag_count + 7'd1;
            v.complete = (frag_count == h.total);
            v.action = ACT_ACCEPTED;
          end else begin
            v.copy = '0;
          end
        end
      end
    end
    return v;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= PRINT_CAP) begin
      $display("mismatch in %0s: got 0x%0h, expected 0x%0h (cycle %0d)",
               what, got, want, cycle_count);
    end
  endtask

  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (verdicts_due.size() == 0) begin
        report_mismatch("unrequested result", 32'(action_o), 32'd0);
      end else begin
        want = verdicts_due.pop_front();
        if (action_o !== want.action)
          report_mismatch("action", 32'(action_o), 32'(want.action));
        if (page_offset_o !== want.offset)
          report_mismatch("page_offset", 32'(page_offset_o), 32'(want.offset));
        if (copy_bytes_o !== want.copy)
          report_mismatch("copy_bytes", 32'(copy_bytes_o), 32'(want.copy));
        if (resend_fragment_bytes_o !== want.resend)
          report_mismatch("resend_fragment_bytes", 32'(resend_fragment_bytes_o),
                          32'(want.resend));
        if (message_complete_o !== want.complete)
          report_mismatch("message_complete", 32'(message_complete_o), 32'(want.complete));
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_off_req != 0) begin
      stall_left = hold_off_req;
      hold_off_req = 0;
    end else if (stall_left == 0 && idling_on && $urandom_range(0, 6) == 0) begin
      stall_left = $urandom_range(1, 14);
    end
    if (stall_left != 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  function automatic header_t packet(input logic [KIND_W-1:0] kind, input logic [15:0] msg,
                                     input logic [7:0] frag, input logic [6:0] total,
                                     input logic [15:0] fbytes, input logic [15:0] hbytes,
                                     input logic [15:0] maxd, input logic pending);
    header_t h;
    h.func = FUNC_PACKET;
    h.kind = kind;
    h.msg = msg;
    h.frag = frag;
    h.total = total;
    h.fbytes = fbytes;
    h.hbytes = hbytes;
    h.maxd = maxd;
    h.pending = pending;
    return h;
  endfunction

  function automatic header_t start_header();
    header_t h;
    h = packet(KIND_DATA, '0, '0, '0, '0, '0, '0, 1'b0);
    h.func = FUNC_START;
    return h;
  endfunction

  function automatic header_t with_sizes(input header_t h);
    h.hbytes = ($urandom_range(0, 7) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 64));
    h.fbytes = ($urandom_range(0, 7) == 0) ? 16'($urandom())
                                          : 16'(32'(h.hbytes) + $urandom_range(0, 3000));
    return h;
  endfunction

  task automatic send_item(input header_t h);
    if (idling_on && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i <= h.func;
    packet_kind_i <= h.kind;
    message_number_i <= h.msg;
    fragment_number_i <= h.frag;
    total_fragments_i <= h.total;
    fragment_bytes_i <= h.fbytes;
    header_bytes_i <= h.hbytes;
    max_data_bytes_i <= h.maxd;
    request_pending_i <= h.pending;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    verdicts_due.push_back(track_fragment(h));
    items_sent++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic set_config(input logic [15:0] msg_hdr, input logic [15:0] pkt_hdr,
                            input logic [15:0] page, input logic [15:0] full_frag);
    cfg_we_i <= 1'b1;
    cfg_index_i <= CFG_MSG_HDR;
    cfg_data_i <= msg_hdr;
    @(posedge clk_i);
    cfg_index_i <= CFG_PKT_HDR;
    cfg_data_i <= pkt_hdr;
    @(posedge clk_i);
    cfg_index_i <= CFG_PAGE;
    cfg_data_i <= page;
    @(posedge clk_i);
    cfg_index_i <= CFG_FULL_FRAG;
    cfg_data_i <= full_frag;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    reg_msg_hdr = msg_hdr;
    reg_pkt_hdr = pkt_hdr;
    reg_page = page;
    reg_full_frag = full_frag;
  endtask

  task automatic send_message();
    header_t     h;
    logic [15:0] msg_no, maxd;
    int unsigned n_frags, j, k, tmp;
    int unsigned order[64];
    if ($urandom_range(0, 5) == 0) send_item(start_header());
    msg_no = msg_is_open ? 16'(open_msg + 16'd1) : 16'($urandom());
    n_frags = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 64) : $urandom_range(1, 8);
    maxd = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(1, 65535))
                                      : 16'($urandom_range(1, 1500));
    h = with_sizes(packet(KIND_DATA, msg_no, 8'd0, 7'(n_frags), '0, '0, maxd,
                          $urandom_range(0, 9) != 0));
    if ($urandom_range(0, 3) == 0) h.fbytes = 16'(reg_pkt_hdr + reg_msg_hdr);
    send_item(h);
    for (k = 0; k + 1 < n_frags; k++) order[k] = k + 1;
    for (k = 0; k + 1 < n_frags; k++) begin
      j = $urandom_range(k, n_frags - 2);
      tmp = order[k];
      order[k] = order[j];
      order[j] = tmp;
    end
    for (k = 0; k + 1 < n_frags; k++) begin
      if ($urandom_range(0, 11) == 0) begin
        send_item(packet(KIND_NACK, msg_no, 8'($urandom_range(0, n_frags - 1)), 7'(n_frags),
                         16'($urandom()), 16'($urandom()), maxd, $urandom_range(0, 3) != 0));
      end
      if ($urandom_range(0, 14) != 0) begin
        h = with_sizes(packet(KIND_DATA, msg_no, 8'(order[k]), 7'(n_frags), '0, '0, maxd,
                              1'($urandom_range(0, 1))));
        send_item(h);
        if ($urandom_range(0, 9) == 0) send_item(h);
      end
    end
  endtask

  task automatic send_noise();
    header_t     h;
    logic [15:0] msg_no;
    int unsigned pick;
    pick = $urandom_range(0, 3);
    msg_no = (pick == 0) ? 16'($urandom()) : (pick == 1) ? 16'(open_msg + 16'd1) : open_msg;
    h = packet(2'($urandom_range(0, 3)), msg_no, 8'($urandom_range(0, 255)),
               7'($urandom_range(0, 127)), 16'($urandom()), 16'($urandom()),
               16'($urandom()), 1'($urandom_range(0, 1)));
    if ($urandom_range(0, 9) == 0) h.func = FUNC_START;
    send_item(h);
  endtask

  task automatic run_traffic(input int unsigned n);
    int unsigned stop_at;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 3) == 0) send_noise();
      else send_message();
    end
  endtask

  task automatic test_directed_cases();
    send_item(start_header());
    send_item(packet(KIND_DATA, 16'd5, 8'd1, 7'd3, 16'd500, 16'd20, 16'd400, 1'b1));
    send_item(packet(KIND_DATA, 16'd7, 8'd0, 7'd3, 16'd500, 16'd20, 16'd400, 1'b0));
    send_item(packet(KIND_OTHER, 16'd7, 8'd0, 7'd3, 16'd500, 16'd20, 16'd400, 1'b1));
    send_item(packet(KIND_RESERVED, 16'd7, 8'd0, 7'd3, 16'd500, 16'd20, 16'd400, 1'b1));
    send_item(packet(KIND_NACK, 16'd7, 8'd1, 7'd3, 16'd0, 16'd0, 16'd400, 1'b0));
    send_item(packet(KIND_DATA, 16'hFFFF, 8'd0, 7'd3, 16'd60, 16'd20, 16'd400, 1'b1));
    send_item(packet(KIND_DATA, 16'hFFFF, 8'd0, 7'd3, 16'd60, 16'd20, 16'd400, 1'b1));
    send_item(packet(KIND_DATA, 16'hFFFF, 8'd1, 7'd3, 16'd10, 16'd20, 16'd400, 1'b1));
    send_item(packet(KIND_DATA, 16'hFFFF, 8'd64, 7'd3, 16'd900, 16'd20, 16'd400, 1'b1));
    send_item(packet(KIND_DATA, 16'hFFFF, 8'd255, 7'd3, 16'd900, 16'd20, 16'd400, 1'b1));
    send_item(packet(KIND_DATA, 16'd100, 8'd2, 7'd3, 16'd900, 16'd20, 16'd400, 1'b1));
    send_item(packet(KIND_DATA, 16'hFFFF, 8'd2, 7'd3, 16'd900, 16'd20, 16'd400, 1'b0));
    send_item(packet(KIND_DATA, 16'd0, 8'd0, 7'd0, 16'd2000, 16'd40, 16'hFFFF, 1'b1));
    send_item(packet(KIND_DATA, 16'd0, 8'd63, 7'd0, 16'hFFFF, 16'd0, 16'hFFFF, 1'b0));
    send_item(packet(KIND_NACK, 16'd0, 8'd0, 7'd5, 16'd0, 16'd0, 16'd10, 1'b1));
    send_item(packet(KIND_NACK, 16'd0, 8'd5, 7'd6, 16'd0, 16'd0, 16'd0, 1'b1));
    send_item(packet(KIND_NACK, 16'd0, 8'd5, 7'd6, 16'd0, 16'd0, 16'd1000, 1'b1));
    send_item(packet(KIND_NACK, 16'd0, 8'd2, 7'd10, 16'd0, 16'd0, 16'd1000, 1'b1));
    send_item(packet(KIND_NACK, 16'd0, 8'd255, 7'd127, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
    send_item(start_header());
    send_item(packet(KIND_DATA, 16'h1234, 8'd0, 7'd100, 16'd300, 16'd8, 16'd200, 1'b1));
    send_item(packet(KIND_DATA, 16'h1234, 8'd1, 7'd100, 16'd300, 16'd8, 16'd200, 1'b1));
    wait_drained();
  endtask

  task automatic test_reset_settings();
    run_traffic(350);
    wait_drained();
  endtask

  task automatic test_smallest_settings();
    set_config(16'd0, 16'd0, 16'd1, 16'd1);
    run_traffic(200);
    wait_drained();
  endtask

  task automatic test_largest_settings();
    set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_traffic(200);
    wait_drained();
  endtask

  task automatic test_random_settings();
    int unsigned round;
    for (round = 0; round < 3; round++) begin
      set_config(16'($urandom_range(0, 512)), 16'($urandom_range(0, 512)),
                 16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)));
      run_traffic(150);
      wait_drained();
    end
  endtask

  task automatic test_backpressure();
    idling_on = 1'b0;
    hold_off_req = HOLD_OFF_LONG;
    run_traffic(60);
    wait_drained();
    idling_on = 1'b1;
  endtask

  task automatic test_steady_stream();
    set_config(16'd32, 16'd28, 16'd4096, 16'd1500);
    idling_on = 1'b0;
    run_traffic(200);
    wait_drained();
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_reset_settings();
    test_smallest_settings();
    test_largest_settings();
    test_random_settings();
    test_backpressure();
    test_steady_stream();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS fragment_reassembly_tracker_core");
    end else begin
      $display("FAIL fragment_reassembly_tracker_core");
    end
    $finish;
  end

endmodule

@@ fragment_reassembly_tracker_core.f @@
+incdir+rtl
rtl/frt_pkg.sv
rtl/fragment_reassembly_tracker_core.sv
rtl/frt_checker.sv
tb/tb_fragment_reassembly_tracker_core.sv
